// ----- design/ola_pkg.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table package
// Shared widths, command and status codes, register indexes and types for the
// lifetime countdown table.
// ----------------------------------------------------------------------------
package ola_pkg;

   // Default table size and field widths.
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ID_W            = 16;
   localparam int CNT_W           = 16;
   localparam int CMD_W           = 2;
   localparam int KIND_W          = 3;
   localparam int STATUS_W        = 3;
   localparam int NUM_KINDS       = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EXPIRED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LASER_LIFE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISSILE_LIFE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUEL_ITEM_LIFE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISSILE_ITEM_LIFE = 2'd3;

   // Lifetime reset values.
   localparam logic [CNT_W-1:0] LASER_LIFE_RST        = 16'd40;
   localparam logic [CNT_W-1:0] MISSILE_LIFE_RST      = 16'd0;
   localparam logic [CNT_W-1:0] FUEL_ITEM_LIFE_RST    = 16'd100;
   localparam logic [CNT_W-1:0] MISSILE_ITEM_LIFE_RST = 16'd100;

   // One lifetime per tracked kind, indexed by kind.
   typedef logic [NUM_KINDS-1:0][CNT_W-1:0] life_tab_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_REPLY
   } state_type;

   // Write controls from the sequencer to the table.
   typedef struct packed {
      logic             key_we;
      logic             cnt_we;
      logic             live_set;
      logic             live_clr;
      logic [ID_W-1:0]  key;
      logic [CNT_W-1:0] count;
   } tbl_wr_type;

endpackage

// ----- design/ola_if.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table channel interfaces
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface ola_req_if;
   import ola_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ID_W-1:0]   object_id;
   logic [KIND_W-1:0] object_kind;

   modport source (output valid, output command, output object_id, output object_kind,
                   input ready);
   modport sink   (input valid, input command, input object_id, input object_kind,
                   output ready);
endinterface

interface ola_rsp_if;
   import ola_pkg::*;

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     result_id;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output result_id, output status, output last,
                   input ready);
   modport sink   (input valid, input result_id, input status, input last,
                   output ready);
endinterface

// ----- design/ola_table.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table storage
// Key and countdown memories with one registered read port and one write
// port, plus a live bit per entry in flip-flops.
// ----------------------------------------------------------------------------
module ola_table #(
   parameter int DEPTH = ola_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [ola_pkg::ID_W-1:0] rd_key,
   output logic [ola_pkg::CNT_W-1:0] rd_count,
   input  ola_pkg::tbl_wr_type      wr,
   input  logic [IDX_W-1:0]         wr_addr,
   output logic [DEPTH-1:0]         live
);
   import ola_pkg::*;

   logic [ID_W-1:0]  key_mem_ff [DEPTH];
   logic [CNT_W-1:0] cnt_mem_ff [DEPTH];
   logic [ID_W-1:0]  rd_key_ff;
   logic [CNT_W-1:0] rd_count_ff;
   logic [DEPTH-1:0] live_ff;
   logic [DEPTH-1:0] live_in;

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem_ff[wr_addr] <= wr.key;
      end
      if (wr.cnt_we) begin
         cnt_mem_ff[wr_addr] <= wr.count;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem_ff[rd_addr];
         rd_count_ff <= cnt_mem_ff[rd_addr];
      end
   end

   // Live bits are set by an insert and cleared by a remove or by an insert with a zero lifetime.
   always_comb begin
      live_in = live_ff;
      if (wr.live_set) begin
         live_in[wr_addr] = 1'b1;
      end
      if (wr.live_clr) begin
         live_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_count = rd_count_ff;
   assign live     = live_ff;

endmodule

// ----- design/ola_ctrl.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table sequencer
// Walks the table one entry per cycle unless an expiry stalls, through a single compare
// and decrement unit, then commits the insert or remove and drives the result register.
// ----------------------------------------------------------------------------
module ola_ctrl #(
   parameter int DEPTH = ola_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   ola_req_if.sink                   req_ch,
   ola_rsp_if.source                 rsp_ch,
   input  ola_pkg::life_tab_type     life_tab,
   output logic                      rd_en,
   output logic [IDX_W-1:0]          rd_addr,
   input  logic [ola_pkg::ID_W-1:0]  rd_key,
   input  logic [ola_pkg::CNT_W-1:0] rd_count,
   output ola_pkg::tbl_wr_type       wr,
   output logic [IDX_W-1:0]          wr_addr,
   input  logic [DEPTH-1:0]          live
);
   import ola_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [CNT_W-1:0]    life_ff, life_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                iss_ff, iss_in;
   logic                p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]    p_idx_ff, p_idx_in;
   logic                match_vld_ff, match_vld_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                cur_live;
   logic                key_hit;
   logic                cnt_nz;
   logic [CNT_W-1:0]    cnt_dec;
   logic                expire;
   logic                emit;
   logic [ID_W-1:0]     emit_id;
   logic [STATUS_W-1:0] emit_status;
   logic                emit_last;

   // Shared compare and decrement unit on the entry just read.
   assign cur_live = live[p_idx_ff];
   assign key_hit  = (rd_key == id_ff);
   assign cnt_nz   = (rd_count != '0);
   assign cnt_dec  = rd_count - CNT_W'(1);
   assign expire   = p_vld_ff && (cmd_ff == CMD_TICK) && cur_live &&
                     (rd_count == CNT_W'(1));

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);

   // Next state, table accesses and result generation.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      life_in      = life_ff;
      idx_in       = idx_ff;
      iss_in       = iss_ff;
      p_vld_in     = p_vld_ff;
      p_idx_in     = p_idx_ff;
      match_vld_in = match_vld_ff;
      match_idx_in = match_idx_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr           = '0;
      wr_addr      = p_idx_ff;
      emit         = 1'b0;
      emit_id      = id_ff;
      emit_status  = STATUS_OK;
      emit_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in       = req_ch.command;
               id_in        = req_ch.object_id;
               life_in      = life_tab[req_ch.object_kind[1:0]];
               idx_in       = '0;
               iss_in       = 1'b1;
               p_vld_in     = 1'b0;
               match_vld_in = 1'b0;
               free_vld_in  = 1'b0;
               priority if (req_ch.command == CMD_TICK ||
                            req_ch.command == CMD_REMOVE) begin
                  state_in = S_SCAN;
               end else if (req_ch.command == CMD_INSERT &&
                            req_ch.object_kind < KIND_W'(NUM_KINDS)) begin
                  state_in = S_SCAN;
               end else begin
                  // Untracked kind or unused command: answer without walking the table.
                  state_in = S_REPLY;
               end
            end
         end

         S_SCAN: begin
            // The whole walk holds while an expiry waits for the result register.
            if (!expire || out_free) begin
               if (iss_ff) begin
                  rd_en    = 1'b1;
                  p_vld_in = 1'b1;
                  p_idx_in = idx_ff;
                  if (idx_ff == LAST_IDX) begin
                     iss_in = 1'b0;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end else begin
                  p_vld_in = 1'b0;
               end

               if (p_vld_ff) begin
                  if (cmd_ff == CMD_TICK) begin
                     if (cur_live && cnt_nz) begin
                        wr.cnt_we = 1'b1;
                        wr.count  = cnt_dec;
                     end
                     if (expire) begin
                        emit        = 1'b1;
                        emit_id     = rd_key;
                        emit_status = STATUS_EXPIRED;
                        emit_last   = 1'b0;
                     end
                  end else begin
                     if (cur_live && key_hit && !match_vld_ff) begin
                        match_vld_in = 1'b1;
                        match_idx_in = p_idx_ff;
                     end
                     if (!cur_live && !free_vld_ff) begin
                        free_vld_in = 1'b1;
                        free_idx_in = p_idx_ff;
                     end
                  end
                  if (!iss_ff) begin
                     state_in = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               unique case (cmd_ff)
                  CMD_TICK: begin
                     emit_id     = '0;
                     emit_status = STATUS_DONE;
                  end
                  CMD_REMOVE: begin
                     if (match_vld_ff) begin
                        wr.live_clr = 1'b1;
                        wr_addr     = match_idx_ff;
                        emit_status = STATUS_OK;
                     end else begin
                        emit_status = STATUS_MISS;
                     end
                  end
                  default: begin
                     // Insert: a zero lifetime frees any entry of the object.
                     priority if (life_ff == '0) begin
                        wr.live_clr = match_vld_ff;
                        wr_addr     = match_idx_ff;
                        emit_status = STATUS_MISS;
                     end else if (match_vld_ff || free_vld_ff) begin
                        wr.key_we   = 1'b1;
                        wr.cnt_we   = 1'b1;
                        wr.live_set = 1'b1;
                        wr.key      = id_ff;
                        wr.count    = life_ff;
                        wr_addr     = match_vld_ff ? match_idx_ff : free_idx_ff;
                        emit_status = STATUS_OK;
                     end else begin
                        emit_status = STATUS_FULL;
                     end
                  end
               endcase
            end
         end

         S_REPLY: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = STATUS_MISS;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   // Result output register.
   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_vld_in    = 1'b1;
         rsp_id_in     = emit_id;
         rsp_status_in = emit_status;
         rsp_last_in   = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         iss_ff     <= 1'b0;
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_ff     <= iss_in;
         p_vld_ff   <= p_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      life_ff       <= life_in;
      idx_ff        <= idx_in;
      p_idx_ff      <= p_idx_in;
      match_vld_ff  <= match_vld_in;
      match_idx_ff  <= match_idx_in;
      free_vld_ff   <= free_vld_in;
      free_idx_ff   <= free_idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

// ----- design/object_lifetime_aging_table_unit.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table
// Insert, remove and tick on a table of per-object lifetime countdowns.
// Holds the lifetime registers and ties the sequencer to the table storage.
// ----------------------------------------------------------------------------
// Insert, remove and tick walk every table entry, one memory read per entry, before
// presenting their last result; an insert of an untracked kind or an unused command
// skips the walk. The next item is accepted in the cycle after the last result is
// queued, so items never overlap. Output stalls delay the results. Synchronous reset
// frees all entries and loads the default lifetimes.
module object_lifetime_aging_table_unit #(
   parameter int TABLE_DEPTH = ola_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ola_req_if.sink                         req_ch,
   ola_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [ola_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ola_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import ola_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   life_tab_type     life_ff, life_in;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ID_W-1:0]  rd_key;
   logic [CNT_W-1:0] rd_count;
   tbl_wr_type       wr;
   logic [IDX_W-1:0] wr_addr;
   logic [TABLE_DEPTH-1:0] live;

   // Lifetime register writes.
   always_comb begin
      life_in = life_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LASER_LIFE:        life_in[0] = csr_wr_data[CNT_W-1:0];
            CSR_MISSILE_LIFE:      life_in[1] = csr_wr_data[CNT_W-1:0];
            CSR_FUEL_ITEM_LIFE:    life_in[2] = csr_wr_data[CNT_W-1:0];
            CSR_MISSILE_ITEM_LIFE: life_in[3] = csr_wr_data[CNT_W-1:0];
            default:               life_in    = life_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff[0] <= LASER_LIFE_RST;
         life_ff[1] <= MISSILE_LIFE_RST;
         life_ff[2] <= FUEL_ITEM_LIFE_RST;
         life_ff[3] <= MISSILE_ITEM_LIFE_RST;
      end else begin
         life_ff <= life_in;
      end
   end

   ola_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .life_tab (life_ff),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_count (rd_count),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .live     (live)
   );

   ola_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_count (rd_count),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .live     (live)
   );

endmodule

// ----- design/ola_checker.sv -----
// ----------------------------------------------------------------------------
// Object lifetime aging table port checker
// Concurrent checks on the channel ports of the top level, bound to it.
// ----------------------------------------------------------------------------
module ola_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ola_pkg::ID_W-1:0]          rsp_result_id,
   input logic [ola_pkg::STATUS_W-1:0]      rsp_status,
   input logic                              rsp_last
);
   import ola_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_id) && $stable(rsp_status) &&
                                  $stable(rsp_last))
      else $error("result payload changed while stalled");

   // No new item is accepted in the cycle right after an acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item accepted right after another");

   // The tick done result closes the item and carries no object.
   a_done_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DONE |-> rsp_last && rsp_result_id == '0)
      else $error("malformed tick done result");

   // Only expiry reports are followed by further results.
   a_not_last_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_EXPIRED)
      else $error("non-final result that is not an expiry");

endmodule

bind object_lifetime_aging_table_unit ola_checker u_ola_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_result_id (rsp_ch.result_id),
   .rsp_status    (rsp_ch.status),
   .rsp_last      (rsp_ch.last)
);
